[hw/rtl/crlsb_pkg.sv]
// ----------------------------------------------------------------------------
// crlsb_pkg
// Shared types and constants for the run-length sprite blitter.
// ----------------------------------------------------------------------------
package crlsb_pkg;

    // Screen coordinate width and clamp for the sprite height
    localparam int COORD_BITS = 12;
    localparam int MAX_HEIGHT = 1023;

    // Register field widths
    localparam int WIDTH_BITS  = 8;
    localparam int HEIGHT_BITS = 10;
    localparam int POS_BITS    = 16;
    localparam int CLIP_LO_BITS = 12;
    localparam int CLIP_HI_BITS = 13;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPRITE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPRITE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POS_X         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POS_Y         = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_LEFT     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_TOP      = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_RIGHT    = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_BOTTOM   = 3'd7;

    // Code stream
    localparam int CODE_BITS   = 8;
    localparam int COLOR_BITS  = 8;
    localparam int COLUMN_BITS = 9;
    localparam int RUN_BITS    = 8;

    // Output data bus: x, y, colour packed from bit 0 up, padded to bytes
    localparam int M_DATA_BITS  = 2 * COORD_BITS + COLOR_BITS;
    localparam int M_TDATA_BITS = ((M_DATA_BITS + 7) / 8) * 8;

    // Decode phase codes
    localparam int PHASE_BITS = 2;
    localparam logic [PHASE_BITS-1:0] PH_SKIP  = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_RUN   = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_PIXEL = 2'd2;

    typedef struct packed {
        logic [WIDTH_BITS-1:0]   sprite_width;
        logic [HEIGHT_BITS-1:0]  sprite_height;
        logic [POS_BITS-1:0]     pos_x;
        logic [POS_BITS-1:0]     pos_y;
        logic [CLIP_LO_BITS-1:0] clip_left;
        logic [CLIP_LO_BITS-1:0] clip_top;
        logic [CLIP_HI_BITS-1:0] clip_right;
        logic [CLIP_HI_BITS-1:0] clip_bottom;
    } cfg_t;

    typedef struct packed {
        logic                  valid;
        logic                  write_enable;
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  sprite_done;
    } result_t;

endpackage

[hw/rtl/clipped_run_length_sprite_blitter.sv]
// ----------------------------------------------------------------------------
// clipped_run_length_sprite_blitter
// Transparent run-length sprite decoder with half-open clip rectangle.
// ----------------------------------------------------------------------------
// Path: a code byte is taken into the input register, decoded from there, and
//   its result, if any, is registered in the output register for the m_ side.
// Throughput: one code byte per cycle unless the output register stalls; the
//   decode state advances in one step between the input and output registers.
// Reset: aresetn is synchronous, active low; it empties both pipeline registers,
//   restores register defaults and puts the decoder at the first skip count.
// ----------------------------------------------------------------------------
module clipped_run_length_sprite_blitter import crlsb_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,

    // configuration write port
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,

    // code byte stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [CODE_BITS-1:0]      s_tdata,   // [7:0] code_byte

    // pixel write stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [M_TDATA_BITS-1:0]   m_tdata,   // pixel_x, pixel_y, pixel_color
    output logic [0:0]                m_tuser,   // [0] write_enable
    output logic                      m_tlast    // sprite_done
);

    cfg_t    cfg;
    result_t result;

    // Input register: one code byte waiting to be decoded
    logic                 in_valid_reg, in_valid_next;
    logic [CODE_BITS-1:0] in_byte_reg;

    // Output register: one finished result waiting to be taken
    logic                  out_valid_reg, out_valid_next;
    logic                  out_we_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic [COLOR_BITS-1:0] out_color_reg;
    logic                  out_done_reg;

    logic advance;
    logic s_take;

    crlsb_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Decode the held byte whenever its result (if any) has a place to go:
    // bytes with no result never wait on the output side.
    assign advance = in_valid_reg &&
                     (!result.valid || !out_valid_reg || m_tready);

    crlsb_decoder u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step_en   (advance),
        .code_byte (in_byte_reg),
        .result    (result)
    );

    // Take a new byte when the input register is empty or drains this cycle
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end

        out_valid_next = out_valid_reg;
        if (advance && result.valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold until replaced, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && result.valid) begin
            out_we_reg    <= result.write_enable;
            out_x_reg     <= result.pixel_x;
            out_y_reg     <= result.pixel_y;
            out_color_reg <= result.pixel_color;
            out_done_reg  <= result.sprite_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_BITS'({out_color_reg, out_y_reg, out_x_reg});
    assign m_tuser  = out_we_reg;
    assign m_tlast  = out_done_reg;

endmodule

[hw/rtl/crlsb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// crlsb_cfg_regs
// Configuration register file, write-only, one register per write.
// ----------------------------------------------------------------------------
module crlsb_cfg_regs import crlsb_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_SPRITE_WIDTH:  cfg_next.sprite_width  = cfg_wdata[WIDTH_BITS-1:0];
                REG_SPRITE_HEIGHT: cfg_next.sprite_height = cfg_wdata[HEIGHT_BITS-1:0];
                REG_POS_X:         cfg_next.pos_x         = cfg_wdata[POS_BITS-1:0];
                REG_POS_Y:         cfg_next.pos_y         = cfg_wdata[POS_BITS-1:0];
                REG_CLIP_LEFT:     cfg_next.clip_left     = cfg_wdata[CLIP_LO_BITS-1:0];
                REG_CLIP_TOP:      cfg_next.clip_top      = cfg_wdata[CLIP_LO_BITS-1:0];
                REG_CLIP_RIGHT:    cfg_next.clip_right    = cfg_wdata[CLIP_HI_BITS-1:0];
                REG_CLIP_BOTTOM:   cfg_next.clip_bottom   = cfg_wdata[CLIP_HI_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sprite_width  <= WIDTH_BITS'(1);
            cfg_reg.sprite_height <= HEIGHT_BITS'(1);
            cfg_reg.pos_x         <= '0;
            cfg_reg.pos_y         <= '0;
            cfg_reg.clip_left     <= '0;
            cfg_reg.clip_top      <= '0;
            cfg_reg.clip_right    <= CLIP_HI_BITS'(4096);
            cfg_reg.clip_bottom   <= CLIP_HI_BITS'(4096);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/crlsb_decoder.sv]
// ----------------------------------------------------------------------------
// crlsb_decoder
// Run-length decode state and the single-step pixel/clip logic.
// ----------------------------------------------------------------------------
module crlsb_decoder import crlsb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 step_en,
    input  logic [CODE_BITS-1:0] code_byte,
    output result_t              result
);

    localparam int SX_BITS = POS_BITS + 2;
    localparam int HCMP_BITS = (HEIGHT_BITS + 1 > 17) ? HEIGHT_BITS + 1 : 17;

    logic [PHASE_BITS-1:0]  phase_reg,  phase_next;
    logic [COLUMN_BITS-1:0] column_reg, column_next;
    logic [HEIGHT_BITS-1:0] row_reg,    row_next;
    logic [RUN_BITS-1:0]    run_reg,    run_next;

    logic signed [SX_BITS-1:0] sx;
    logic signed [SX_BITS-1:0] sy;
    logic                      x_ok;
    logic                      y_ok;
    logic [COLUMN_BITS-1:0]    col_inc;
    logic [COLUMN_BITS-1:0]    col_sum;
    logic [RUN_BITS-1:0]       run_dec;
    logic [HEIGHT_BITS:0]      row_inc;
    logic [HCMP_BITS-1:0]      height_eff;
    logic                      last_row;
    logic                      row_end;
    logic                      we;
    logic                      done;
    logic [COLUMN_BITS-1:0]    width_ext;

    always_comb begin
        sx = {{2{cfg.pos_x[POS_BITS-1]}}, cfg.pos_x} +
             SX_BITS'({1'b0, column_reg});
        sy = {{2{cfg.pos_y[POS_BITS-1]}}, cfg.pos_y} +
             SX_BITS'({1'b0, row_reg});

        // on screen (0 <= v < 2^COORD_BITS) and inside the half-open clip
        x_ok = (sx[SX_BITS-1:COORD_BITS] == '0) &&
               (unsigned'(sx) >= SX_BITS'(cfg.clip_left)) &&
               (unsigned'(sx) <  SX_BITS'(cfg.clip_right));
        y_ok = (sy[SX_BITS-1:COORD_BITS] == '0) &&
               (unsigned'(sy) >= SX_BITS'(cfg.clip_top)) &&
               (unsigned'(sy) <  SX_BITS'(cfg.clip_bottom));

        width_ext = COLUMN_BITS'(cfg.sprite_width);
        col_inc   = column_reg + COLUMN_BITS'(1);
        col_sum   = column_reg + COLUMN_BITS'(code_byte);
        run_dec   = run_reg - RUN_BITS'(1);
        row_inc   = {1'b0, row_reg} + (HEIGHT_BITS+1)'(1);

        height_eff = (HCMP_BITS'(cfg.sprite_height) > HCMP_BITS'(MAX_HEIGHT)) ?
                     HCMP_BITS'(MAX_HEIGHT) : HCMP_BITS'(cfg.sprite_height);
        last_row   = (HCMP_BITS'(row_inc) >= height_eff);

        phase_next  = phase_reg;
        column_next = column_reg;
        row_next    = row_reg;
        run_next    = run_reg;
        row_end     = 1'b0;
        we          = 1'b0;
        done        = 1'b0;

        unique case (phase_reg)
            PH_RUN: begin
                run_next   = code_byte;
                phase_next = (code_byte == '0) ? PH_SKIP : PH_PIXEL;
            end
            PH_PIXEL: begin
                we          = (column_reg < width_ext) && x_ok && y_ok;
                column_next = col_inc;
                run_next    = run_dec;
                if (run_dec == '0) begin
                    if (col_inc >= width_ext) begin
                        row_end = 1'b1;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            default: begin
                // skip count; the spare phase code decodes the same way
                column_next = col_sum;
                if (col_sum >= width_ext) begin
                    row_end = 1'b1;
                end else begin
                    phase_next = PH_RUN;
                end
            end
        endcase

        if (row_end) begin
            phase_next  = PH_SKIP;
            column_next = '0;
            run_next    = '0;
            if (last_row) begin
                row_next = '0;
                done     = 1'b1;
            end else begin
                row_next = row_inc[HEIGHT_BITS-1:0];
            end
        end

        result.valid        = we || done;
        result.write_enable = we;
        result.pixel_x      = we ? sx[COORD_BITS-1:0] : '0;
        result.pixel_y      = we ? sy[COORD_BITS-1:0] : '0;
        result.pixel_color  = we ? code_byte : '0;
        result.sprite_done  = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SKIP;
            column_reg <= '0;
            row_reg    <= '0;
            run_reg    <= '0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            column_reg <= column_next;
            row_reg    <= row_next;
            run_reg    <= run_next;
        end
    end

endmodule
